// File: design/wss_pkg.sv
package wss_pkg;

  localparam int WORD_W      = 32;
  localparam int WORD_W1     = WORD_W + 1;
  localparam int TS_W        = 16;
  localparam int ALEN_W      = 9;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 8;
  localparam int PIPE_STAGES = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [WORD_W-1:0] STIFF_RST = 32'd1572864;
  localparam logic [TS_W-1:0]   TS_RST    = 16'd6554;
  localparam logic              FIXED_RST = 1'b1;
  localparam logic [ALEN_W-1:0] ALEN_RST  = 9'd256;

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_SET  = 2'd1,
    CMD_ADD  = 2'd2,
    CMD_READ = 2'd3
  } wss_cmd_t;

  typedef enum logic [1:0] {
    CFG_STIFFNESS     = 2'd0,
    CFG_TIME_STEP     = 2'd1,
    CFG_FIXED_ENDS    = 2'd2,
    CFG_ACTIVE_LENGTH = 2'd3
  } wss_cfg_t;

  // Stencil used for the cell at the update unit input
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_INNER  = 2'd1,
    KIND_END_LO = 2'd2,
    KIND_END_HI = 2'd3
  } wss_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PASS = 2'd1,
    ST_HOLD = 2'd2
  } wss_state_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos;
    logic signed [WORD_W-1:0] vel;
  } wss_entry_t;

  typedef struct packed {
    logic      upd;
    wss_kind_t kind;
  } wss_ctl_t;

  // Signed add, saturated to the word range
  function automatic logic signed [WORD_W-1:0] sat_add(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    logic signed [WORD_W:0] sum;
    sum = WORD_W1'(a) + WORD_W1'(b);
    if (sum[WORD_W] != sum[WORD_W-1]) begin
      sat_add = sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat_add = sum[WORD_W-1:0];
    end
  endfunction

endpackage

// File: design/wss_cell.sv
module wss_cell
  import wss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  wss_entry_t d,
  output wss_entry_t q
);

  wss_entry_t ent_r;

  // Hold one string point; pass it on to the neighbor on every advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (adv) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

// File: design/wss_update.sv
module wss_update
  import wss_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  wss_ctl_t                 ctl,
  input  wss_entry_t               head,
  input  logic signed [WORD_W-1:0] next_pos,
  input  logic [WORD_W-1:0]        stiffness,
  input  logic [TS_W-1:0]          time_step,
  output wss_entry_t               wb
);

  localparam int DIFF_W    = WORD_W + 2;
  localparam int MAG_W     = WORD_W + 1;
  localparam int PROD_W    = WORD_W + MAG_W;
  localparam int RCP_SHIFT = MAG_W + 1;
  localparam int RCP_W     = 2 * MAG_W;
  localparam int MUL_W     = WORD_W + TS_W;
  localparam logic [MAG_W-1:0]  RECIP3  = MAG_W'(((64'd1 << RCP_SHIFT) + 64'd2) / 64'd3);
  localparam logic [PROD_W-1:0] LIM3    = PROD_W'(3) << (WORD_W - 1);
  localparam logic [PROD_W-1:0] LIM2    = PROD_W'(1) << WORD_W;
  localparam logic [WORD_W-1:0] MAG_MIN = WORD_W'(1) << (WORD_W - 1);
  localparam logic [WORD_W-1:0] MAG_MAX = MAG_MIN - WORD_W'(1);

  logic signed [WORD_W-1:0] prev_pos_r;

  logic [MAG_W-1:0]  s1_mag_r;
  logic              s1_neg_r, s1_div3_r, s1_upd_r;
  wss_entry_t        s1_ent_r;
  logic [PROD_W-1:0] s2_prod_r;
  logic              s2_neg_r, s2_div3_r, s2_upd_r;
  wss_entry_t        s2_ent_r;
  logic [MAG_W-1:0]  s3_tq_r;
  logic              s3_sat_r, s3_neg_r, s3_div3_r, s3_upd_r;
  wss_entry_t        s3_ent_r;
  logic [WORD_W-1:0] s4_amag_r;
  logic              s4_neg_r, s4_upd_r;
  wss_entry_t        s4_ent_r;
  logic [WORD_W-1:0] s5_dvm_r;
  logic              s5_neg_r, s5_upd_r;
  wss_entry_t        s5_ent_r;
  logic              s6_upd_r;
  wss_entry_t        s6_ent_r;
  logic [WORD_W-1:0] s7_dpm_r;
  logic              s7_neg_r, s7_upd_r;
  wss_entry_t        s7_ent_r;
  wss_entry_t        s8_ent_r;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        dmag;
  logic                     dneg;
  logic [PROD_W-1:0]        prod, tshift;
  logic                     tsat;
  logic [RCP_W-1:0]         prod3;
  logic [WORD_W-1:0]        q, amag;
  logic [MUL_W-1:0]         dv_prod, dp_prod;
  logic signed [WORD_W-1:0] vnew, pnew;
  logic [WORD_W-1:0]        vmag;
  logic                     vneg;

  // Neighbor difference from the old positions
  always_comb begin
    case (ctl.kind)
      KIND_INNER:  diff = DIFF_W'(prev_pos_r) + DIFF_W'(next_pos) - (DIFF_W'(head.pos) <<< 1);
      KIND_END_LO: diff = DIFF_W'(next_pos) - DIFF_W'(head.pos);
      KIND_END_HI: diff = DIFF_W'(prev_pos_r) - DIFF_W'(head.pos);
      default:     diff = '0;
    endcase
    dneg = diff[DIFF_W-1];
    dmag = dneg ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_comb begin
    prod   = PROD_W'(stiffness) * PROD_W'(s1_mag_r);
    tshift = s2_prod_r >> FRAC_BITS;
    tsat   = s2_div3_r ? (tshift >= LIM3) : (tshift >= LIM2);
    prod3  = RCP_W'(s3_tq_r) * RCP_W'(RECIP3);
    if (s3_sat_r) begin
      q = MAG_MIN;
    end else if (s3_div3_r) begin
      q = prod3[RCP_SHIFT +: WORD_W];
    end else begin
      q = s3_tq_r[1 +: WORD_W];
    end
    amag    = (!s3_neg_r && (q == MAG_MIN)) ? MAG_MAX : q;
    dv_prod = MUL_W'(s4_amag_r) * MUL_W'(time_step);
    vnew    = s5_upd_r ? sat_add(s5_ent_r.vel, s5_neg_r ? -s5_dvm_r : s5_dvm_r)
                       : s5_ent_r.vel;
    vneg    = s6_ent_r.vel[WORD_W-1];
    vmag    = vneg ? WORD_W'(-s6_ent_r.vel) : WORD_W'(s6_ent_r.vel);
    dp_prod = MUL_W'(vmag) * MUL_W'(time_step);
    pnew    = s7_upd_r ? sat_add(s7_ent_r.pos, s7_neg_r ? -s7_dpm_r : s7_dpm_r)
                       : s7_ent_r.pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_upd_r <= 1'b0;
      s2_upd_r <= 1'b0;
      s3_upd_r <= 1'b0;
      s4_upd_r <= 1'b0;
      s5_upd_r <= 1'b0;
      s6_upd_r <= 1'b0;
      s7_upd_r <= 1'b0;
    end else if (adv) begin
      s1_upd_r <= ctl.upd;
      s2_upd_r <= s1_upd_r;
      s3_upd_r <= s2_upd_r;
      s4_upd_r <= s3_upd_r;
      s5_upd_r <= s4_upd_r;
      s6_upd_r <= s5_upd_r;
      s7_upd_r <= s6_upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_pos_r <= head.pos;
      s1_mag_r   <= dmag[MAG_W-1:0];
      s1_neg_r   <= dneg;
      s1_div3_r  <= (ctl.kind == KIND_INNER);
      s1_ent_r   <= head;
      s2_prod_r  <= prod;
      s2_neg_r   <= s1_neg_r;
      s2_div3_r  <= s1_div3_r;
      s2_ent_r   <= s1_ent_r;
      s3_tq_r    <= tshift[MAG_W-1:0];
      s3_sat_r   <= tsat;
      s3_neg_r   <= s2_neg_r;
      s3_div3_r  <= s2_div3_r;
      s3_ent_r   <= s2_ent_r;
      s4_amag_r  <= amag;
      s4_neg_r   <= s3_neg_r;
      s4_ent_r   <= s3_ent_r;
      s5_dvm_r   <= dv_prod[TS_W +: WORD_W];
      s5_neg_r   <= s4_neg_r;
      s5_ent_r   <= s4_ent_r;
      s6_ent_r   <= '{pos: s5_ent_r.pos, vel: vnew};
      s7_dpm_r   <= dp_prod[TS_W +: WORD_W];
      s7_neg_r   <= vneg;
      s7_ent_r   <= s6_ent_r;
      s8_ent_r   <= '{pos: pnew, vel: s7_ent_r.vel};
    end
  end

  assign wb = s8_ent_r;

endmodule

// File: design/wave_string_step_top.sv
// Channel  | Ports                                            | Direction
// ---------+--------------------------------------------------+----------
// in       | in_valid, in_stall, in_cmd, in_cell_index,       | to block
//          | in_value_in                                      |
// out      | out_valid, out_stall, out_position_out,          | from block
//          | out_step_done                                    |
// cfg      | cfg_we, cfg_index, cfg_wdata                     | to block
//
// Each command takes one ring turn through the cells and the 8-stage update pipeline; no
// new command is taken during the turn. The result loads on the last advance unless the
// output slot is stalled, and the input reopens once the sequencer is back in idle.
// Synchronous reset (rst_n low) clears every cell and loads the register defaults.
// A finished command whose result slot is still stalled holds and stalls the input
// until the earlier beat is taken; a waiting result alone never blocks a new command.
module wave_string_step_top
  import wss_pkg::*;
#(
  parameter int CELLS     = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [IDX_W-1:0]         in_cell_index,
  input  logic signed [WORD_W-1:0] in_value_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_position_out,
  output logic                     out_step_done
);

  localparam int RING_LEN = CELLS + PIPE_STAGES;
  localparam int CNT_W    = $clog2(RING_LEN);

  // Configuration registers
  logic [WORD_W-1:0] stiffness_r;
  logic [TS_W-1:0]   time_step_r;
  logic              fixed_ends_r;
  logic [ALEN_W-1:0] active_length_r;

  wss_state_t state_r, state_nxt;
  logic       adv, load_out, pass_end, in_accept;

  // Latched command
  wss_cmd_t                 cmd_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [WORD_W-1:0] val_r;
  logic [CNT_W-1:0]         len_r, len_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [WORD_W-1:0] res_r;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_position_r;
  logic                     out_step_done_r;

  // Ring of cells: chain_q[0] is the head feeding the update unit
  wss_entry_t chain_q [CELLS];
  wss_entry_t wb, head_ent;
  wss_ctl_t   ctl;
  logic       is_lo, is_hi, is_inner, match;
  logic signed [WORD_W-1:0] p_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r     <= STIFF_RST;
      time_step_r     <= TS_RST;
      fixed_ends_r    <= FIXED_RST;
      active_length_r <= ALEN_RST;
    end else if (cfg_we) begin
      case (wss_cfg_t'(cfg_index))
        CFG_STIFFNESS:     stiffness_r     <= cfg_wdata[WORD_W-1:0];
        CFG_TIME_STEP:     time_step_r     <= cfg_wdata[TS_W-1:0];
        CFG_FIXED_ENDS:    fixed_ends_r    <= cfg_wdata[0];
        CFG_ACTIVE_LENGTH: active_length_r <= cfg_wdata[ALEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the active length into 3..CELLS
  always_comb begin
    if (int'(active_length_r) < 3) begin
      len_nxt = CNT_W'(3);
    end else if (int'(active_length_r) > CELLS) begin
      len_nxt = CNT_W'(CELLS);
    end else begin
      len_nxt = CNT_W'(active_length_r);
    end
  end

  // Sequencer: idle, one ring turn, then hold while the output slot is busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign pass_end = (cnt_r == CNT_W'(RING_LEN - 1));

  always_comb begin
    state_nxt = state_r;
    adv       = 1'b0;
    load_out  = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        adv = 1'b1;
        if (pass_end) begin
          if (!out_valid_r || !out_stall) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  // Role of the cell now at the head; cnt_r is its index during a turn
  always_comb begin
    is_lo    = (cnt_r == '0);
    is_hi    = (cnt_r == len_r - CNT_W'(1));
    is_inner = !is_lo && (cnt_r < len_r - CNT_W'(1));
    if (is_inner) begin
      ctl.kind = KIND_INNER;
    end else if (is_lo) begin
      ctl.kind = KIND_END_LO;
    end else if (is_hi) begin
      ctl.kind = KIND_END_HI;
    end else begin
      ctl.kind = KIND_NONE;
    end
    ctl.upd = (cmd_r == CMD_STEP) && (is_inner || (!fixed_ends_r && (is_lo || is_hi)));
  end

  // Set, add and read act on the addressed cell as it passes the head
  always_comb begin
    match = (cmd_r != CMD_STEP) && (int'(cnt_r) < CELLS) && (int'(cnt_r) == int'(idx_r));
    p_in  = chain_q[0].pos;
    if (match) begin
      case (cmd_r)
        CMD_SET: p_in = val_r;
        CMD_ADD: p_in = sat_add(chain_q[0].pos, val_r);
        default: p_in = chain_q[0].pos;
      endcase
    end
    head_ent = '{pos: p_in, vel: chain_q[0].vel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        cnt_r <= '0;
      end else if (adv && !pass_end) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= wss_cmd_t'(in_cmd);
      idx_r <= in_cell_index;
      val_r <= in_value_in;
      len_r <= len_nxt;
      res_r <= '0;
    end else if (adv && match) begin
      res_r <= p_in;
    end
    if (load_out) begin
      out_position_r  <= res_r;
      out_step_done_r <= (cmd_r == CMD_STEP);
    end
  end

  // Cell chain: advance toward the head, refill the tail from the update unit
  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    if (j == CELLS - 1) begin : g_tail
      wss_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (wb),
        .q     (chain_q[j])
      );
    end else begin : g_body
      wss_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .d     (chain_q[j+1]),
        .q     (chain_q[j])
      );
    end
  end

  wss_update #(
    .FRAC_BITS (FRAC_BITS)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl       (ctl),
    .head      (head_ent),
    .next_pos  (chain_q[1].pos),
    .stiffness (stiffness_r),
    .time_step (time_step_r),
    .wb        (wb)
  );

  assign out_valid        = out_valid_r;
  assign out_position_out = out_position_r;
  assign out_step_done    = out_step_done_r;

  // A time step reports position zero
  a_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_done |-> out_position_out == '0)
    else $error("step beat with nonzero position");

  // An accepted beat starts a turn at the ring head
  a_turn_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_PASS && cnt_r == '0)
    else $error("turn did not start at the head");

  // A new result only appears after a completed turn
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_PASS || $past(state_r) == ST_HOLD)
    else $error("result without a finished turn");

endmodule
